@@ rtl/rvdec_pkg.sv @@
package rvdec_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [5:0] F6_BASE = 6'b000000;
  localparam logic [5:0] F6_ALT  = 6'b010000;

  // Mnemonic codes
  localparam logic [5:0] MN_INVALID = 6'd0;
  localparam logic [5:0] MN_ADD  = 6'd1;
  localparam logic [5:0] MN_SUB  = 6'd2;
  localparam logic [5:0] MN_AND  = 6'd3;
  localparam logic [5:0] MN_OR   = 6'd4;
  localparam logic [5:0] MN_XOR  = 6'd5;
  localparam logic [5:0] MN_SLL  = 6'd6;
  localparam logic [5:0] MN_SRL  = 6'd7;
  localparam logic [5:0] MN_SRA  = 6'd8;
  localparam logic [5:0] MN_ADDI = 6'd9;
  localparam logic [5:0] MN_ANDI = 6'd10;
  localparam logic [5:0] MN_ORI  = 6'd11;
  localparam logic [5:0] MN_XORI = 6'd12;
  localparam logic [5:0] MN_SLLI = 6'd13;
  localparam logic [5:0] MN_SRLI = 6'd14;
  localparam logic [5:0] MN_SRAI = 6'd15;
  localparam logic [5:0] MN_LB   = 6'd16;
  localparam logic [5:0] MN_LH   = 6'd17;
  localparam logic [5:0] MN_LW   = 6'd18;
  localparam logic [5:0] MN_LD   = 6'd19;
  localparam logic [5:0] MN_LBU  = 6'd20;
  localparam logic [5:0] MN_LHU  = 6'd21;
  localparam logic [5:0] MN_LWU  = 6'd22;
  localparam logic [5:0] MN_SB   = 6'd23;
  localparam logic [5:0] MN_SH   = 6'd24;
  localparam logic [5:0] MN_SW   = 6'd25;
  localparam logic [5:0] MN_SD   = 6'd26;
  localparam logic [5:0] MN_BEQ  = 6'd27;
  localparam logic [5:0] MN_BNE  = 6'd28;
  localparam logic [5:0] MN_BLT  = 6'd29;
  localparam logic [5:0] MN_BGE  = 6'd30;
  localparam logic [5:0] MN_BLTU = 6'd31;
  localparam logic [5:0] MN_BGEU = 6'd32;
  localparam logic [5:0] MN_JAL  = 6'd33;
  localparam logic [5:0] MN_JALR = 6'd34;
  localparam logic [5:0] MN_LUI  = 6'd35;

  // Decoded fields handed from the decoder to the target unit and result register
  typedef struct packed {
    logic [5:0]  mnemonic;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm;
    logic        jump;
  } dec_t;

endpackage

@@ rtl/rvdec_decode.sv @@
module rvdec_decode
  import rvdec_pkg::*;
(
  input  logic [31:0] instr_word,
  output dec_t        dec
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  f6;
  logic [20:0] imm_i;
  dec_t        raw;

  assign opc   = instr_word[6:0];
  assign f3    = instr_word[14:12];
  assign f7    = instr_word[31:25];
  assign f6    = instr_word[31:26];
  assign imm_i = {{9{instr_word[31]}}, instr_word[31:20]};

  always_comb begin
    raw          = '0;
    raw.mnemonic = MN_INVALID;
    case (opc)
      OPC_OP: begin
        raw.rd  = instr_word[11:7];
        raw.rs1 = instr_word[19:15];
        raw.rs2 = instr_word[24:20];
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0:    raw.mnemonic = MN_ADD;
            3'd1:    raw.mnemonic = MN_SLL;
            3'd4:    raw.mnemonic = MN_XOR;
            3'd5:    raw.mnemonic = MN_SRL;
            3'd6:    raw.mnemonic = MN_OR;
            3'd7:    raw.mnemonic = MN_AND;
            default: raw.mnemonic = MN_INVALID;
          endcase
        end else if (f7 == F7_ALT) begin
          case (f3)
            3'd0:    raw.mnemonic = MN_SUB;
            3'd5:    raw.mnemonic = MN_SRA;
            default: raw.mnemonic = MN_INVALID;
          endcase
        end
      end
      OPC_OPIMM: begin
        raw.rd  = instr_word[11:7];
        raw.rs1 = instr_word[19:15];
        if (f3 inside {3'd0, 3'd4, 3'd6, 3'd7}) begin
          raw.imm = imm_i;
          case (f3)
            3'd0:    raw.mnemonic = MN_ADDI;
            3'd4:    raw.mnemonic = MN_XORI;
            3'd6:    raw.mnemonic = MN_ORI;
            default: raw.mnemonic = MN_ANDI;
          endcase
        end else begin
          // shifts: 6-bit shamt, funct6 selects logical/arithmetic
          raw.imm = {15'd0, instr_word[25:20]};
          if (f3 == 3'd1 && f6 == F6_BASE)      raw.mnemonic = MN_SLLI;
          else if (f3 == 3'd5 && f6 == F6_BASE) raw.mnemonic = MN_SRLI;
          else if (f3 == 3'd5 && f6 == F6_ALT)  raw.mnemonic = MN_SRAI;
        end
      end
      OPC_LOAD: begin
        raw.rd  = instr_word[11:7];
        raw.rs1 = instr_word[19:15];
        raw.imm = imm_i;
        case (f3)
          3'd0:    raw.mnemonic = MN_LB;
          3'd1:    raw.mnemonic = MN_LH;
          3'd2:    raw.mnemonic = MN_LW;
          3'd3:    raw.mnemonic = MN_LD;
          3'd4:    raw.mnemonic = MN_LBU;
          3'd5:    raw.mnemonic = MN_LHU;
          3'd6:    raw.mnemonic = MN_LWU;
          default: raw.mnemonic = MN_INVALID;
        endcase
      end
      OPC_STORE: begin
        raw.rs1 = instr_word[19:15];
        raw.rs2 = instr_word[24:20];
        raw.imm = {{9{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
        case (f3)
          3'd0:    raw.mnemonic = MN_SB;
          3'd1:    raw.mnemonic = MN_SH;
          3'd2:    raw.mnemonic = MN_SW;
          3'd3:    raw.mnemonic = MN_SD;
          default: raw.mnemonic = MN_INVALID;
        endcase
      end
      OPC_BRANCH: begin
        raw.rs1  = instr_word[19:15];
        raw.rs2  = instr_word[24:20];
        raw.jump = 1'b1;
        raw.imm  = {{8{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
        case (f3)
          3'd0:    raw.mnemonic = MN_BEQ;
          3'd1:    raw.mnemonic = MN_BNE;
          3'd4:    raw.mnemonic = MN_BLT;
          3'd5:    raw.mnemonic = MN_BGE;
          3'd6:    raw.mnemonic = MN_BLTU;
          3'd7:    raw.mnemonic = MN_BGEU;
          default: raw.mnemonic = MN_INVALID;
        endcase
      end
      OPC_JAL: begin
        raw.mnemonic = MN_JAL;
        raw.rd       = instr_word[11:7];
        raw.jump     = 1'b1;
        raw.imm      = {instr_word[31], instr_word[19:12], instr_word[20],
                        instr_word[30:21], 1'b0};
      end
      OPC_JALR: begin
        raw.mnemonic = (f3 == 3'd0) ? MN_JALR : MN_INVALID;
        raw.rd       = instr_word[11:7];
        raw.rs1      = instr_word[19:15];
        raw.imm      = imm_i;
      end
      OPC_LUI: begin
        raw.mnemonic = MN_LUI;
        raw.rd       = instr_word[11:7];
        raw.imm      = {1'b0, instr_word[31:12]};
      end
      default: raw.mnemonic = MN_INVALID;
    endcase
  end

  // invalid encodings report all-zero operands
  assign dec = (raw.mnemonic == MN_INVALID) ? '0 : raw;

endmodule

@@ rtl/rvdec_target.sv @@
module rvdec_target
  import rvdec_pkg::*;
(
  input  dec_t        dec,
  input  logic [15:0] line_number,
  output logic        has_target,
  output logic [18:0] target_line
);

  logic [20:0] imm_adj;
  logic [18:0] quot;
  logic [19:0] sum;

  // offset/4 rounded toward zero: bias negatives by 3 before the shift
  assign imm_adj = dec.imm + {19'd0, dec.imm[20], dec.imm[20]};
  assign quot    = imm_adj[20:2];
  assign sum     = {quot[18], quot} + {4'd0, line_number};

  assign has_target  = dec.jump && !sum[19];
  assign target_line = has_target ? sum[18:0] : 19'd0;

endmodule

@@ rtl/rv64i_instruction_decoder_core.sv @@
// RV64I instruction decoder. Each transfer on the input channel carries one
// 32-bit instruction word and its one-based line number; each transfer on
// the output channel returns one decoded result: mnemonic code (0 = invalid,
// 1..35 = add..lui), rd/rs1/rs2 (zero where the format has no such field),
// the sign-extended immediate (shamt for immediate shifts, raw upper 20 bits
// for lui) and, for branches and jal, the target line = line + offset/4
// truncated toward zero, flagged by has_target when non-negative. Invalid
// encodings return all-zero fields. Throughput is one instruction per clock
// while out_ready is high. The path is one input register, the decode and
// target add, then one result register. Both stages hold their contents
// under back-pressure, so in_ready drops only when both stages are full and
// out_ready is low.
module rv64i_instruction_decoder_core
  import rvdec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instr_word,
  input  logic [15:0]        line_number,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         mnemonic,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic signed [20:0] immediate,
  output logic               has_target,
  output logic [18:0]        target_line
);

  // input stage
  logic        in_full;
  logic [31:0] word_q;
  logic [15:0] line_q;

  // decode results
  dec_t        dec;
  logic        tgt_has;
  logic [18:0] tgt_line;

  logic        out_load;

  // result register frees when empty or when its transfer completes
  assign out_load = !out_valid || out_ready;
  assign in_ready = !in_full || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_q <= instr_word;
      line_q <= line_number;
    end
  end

  rvdec_decode u_decode (
    .instr_word (word_q),
    .dec        (dec)
  );

  rvdec_target u_target (
    .dec         (dec),
    .line_number (line_q),
    .has_target  (tgt_has),
    .target_line (tgt_line)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_full) begin
      mnemonic    <= dec.mnemonic;
      dest_reg    <= dec.rd;
      src1_reg    <= dec.rs1;
      src2_reg    <= dec.rs2;
      immediate   <= dec.imm;
      has_target  <= tgt_has;
      target_line <= tgt_line;
    end
  end

`ifndef SYNTHESIS
  // only branches and jal carry a target
  assert property (@(posedge clk) disable iff (rst)
    out_valid && has_target |-> (mnemonic >= MN_BEQ && mnemonic <= MN_JAL))
    else $error("has_target on a non-jump mnemonic");

  // invalid encodings report zero operands
  assert property (@(posedge clk) disable iff (rst)
    out_valid && mnemonic == MN_INVALID |->
      (dest_reg == 5'd0 && src1_reg == 5'd0 && src2_reg == 5'd0 &&
       immediate == 21'sd0 && !has_target))
    else $error("invalid encoding with nonzero fields");

  // a target line without the flag means a lost clear
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_target |-> target_line == 19'd0)
    else $error("target_line set without has_target");

  // an accepted word lands in the input stage
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> in_full)
    else $error("accepted word not held in input stage");

  // a full input stage moves on whenever the result register frees
  assert property (@(posedge clk) disable iff (rst)
    in_full && out_load |=> out_valid)
    else $error("decoded word not passed to result register");
`endif

endmodule

@@ tb/rv64i_instruction_decoder_core_test.sv @@
module rv64i_instruction_decoder_core_test;
  import rvdec_pkg::*;

  // funct3 values not named in the package
  localparam logic [2:0] F3_ADD_SUB     = 3'd0;
  localparam logic [2:0] F3_SLL         = 3'd1;
  localparam logic [2:0] F3_SLT         = 3'd2;
  localparam logic [2:0] F3_XOR         = 3'd4;
  localparam logic [2:0] F3_SRL_SRA     = 3'd5;
  localparam logic [2:0] F3_OR          = 3'd6;
  localparam logic [2:0] F3_AND         = 3'd7;
  localparam logic [2:0] F3_LOAD_NONE   = 3'd7;
  localparam logic [2:0] F3_STORE_NONE  = 3'd4;
  localparam logic [2:0] F3_BEQ         = 3'd0;
  localparam logic [2:0] F3_BNE         = 3'd1;
  localparam logic [2:0] F3_BRANCH_NONE = 3'd2;
  localparam logic [2:0] F3_BLT         = 3'd4;
  localparam logic [2:0] F3_BGE         = 3'd5;
  localparam logic [2:0] F3_BLTU        = 3'd6;
  localparam logic [2:0] F3_BGEU        = 3'd7;
  localparam logic [2:0] F3_JALR        = 3'd0;
  localparam logic [2:0] F3_JALR_NONE   = 3'd1;

  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [5:0]  mnemonic;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm;
    logic        has_target;
    logic [18:0] target_line;
  } decoded_t;

  typedef struct {
    logic [31:0] word;
    logic [15:0] line;
    bit          drain;   // hold this one back until every decode is back
  } listing_entry_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        instr_word;
  logic [15:0]        line_number;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         mnemonic;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [20:0] immediate;
  logic               has_target;
  logic [18:0]        target_line;

  listing_entry_t instr_queue[$];     // words waiting to be sent
  decoded_t       pending_decodes[$]; // predicted decodes of words already taken
  listing_entry_t next_entry;

  int  errors = 0;
  int  words_taken = 0;
  int  words_total;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  burst = 0;
  bit  in_xfer = 0;   // input transfer happened at the last rising edge
  logic [5:0] mn_pick;
  logic [31:0] noise_word;

  rv64i_instruction_decoder_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .instr_word  (instr_word),
    .line_number (line_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mnemonic    (mnemonic),
    .dest_reg    (dest_reg),
    .src1_reg    (src1_reg),
    .src2_reg    (src2_reg),
    .immediate   (immediate),
    .has_target  (has_target),
    .target_line (target_line)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: decode one word the way the block should.
  // ---------------------------------------------------------------------------
  function automatic decoded_t decode_instr(logic [31:0] w, logic [15:0] line);
    decoded_t   r;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] f6;
    int         imm;
    int         ln;
    int         dest;
    bit         jumps;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    f6    = w[31:26];
    r     = '0;
    imm   = 0;
    jumps = 0;
    ln    = line;
    case (opc)
      OPC_OP: begin
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD_SUB: r.mnemonic = MN_ADD;
            F3_SLL:     r.mnemonic = MN_SLL;
            F3_XOR:     r.mnemonic = MN_XOR;
            F3_SRL_SRA: r.mnemonic = MN_SRL;
            F3_OR:      r.mnemonic = MN_OR;
            F3_AND:     r.mnemonic = MN_AND;
            default:    r.mnemonic = MN_INVALID;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD_SUB) r.mnemonic = MN_SUB;
          else if (f3 == F3_SRL_SRA) r.mnemonic = MN_SRA;
        end
      end
      OPC_OPIMM: begin
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        case (f3)
          F3_ADD_SUB, F3_AND, F3_OR, F3_XOR: begin
            imm = $signed(w[31:20]);
            case (f3)
              F3_ADD_SUB: r.mnemonic = MN_ADDI;
              F3_AND:     r.mnemonic = MN_ANDI;
              F3_OR:      r.mnemonic = MN_ORI;
              default:    r.mnemonic = MN_XORI;
            endcase
          end
          default: begin
            // shifts carry a 6-bit shamt, funct6 picks the kind
            imm = w[25:20];
            if (f3 == F3_SLL && f6 == F6_BASE) r.mnemonic = MN_SLLI;
            else if (f3 == F3_SRL_SRA && f6 == F6_BASE) r.mnemonic = MN_SRLI;
            else if (f3 == F3_SRL_SRA && f6 == F6_ALT) r.mnemonic = MN_SRAI;
          end
        endcase
      end
      OPC_LOAD: begin
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        imm   = $signed(w[31:20]);
        if (f3 != F3_LOAD_NONE) r.mnemonic = MN_LB + f3;
      end
      OPC_STORE: begin
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        imm   = $signed({w[31:25], w[11:7]});
        if (f3 < F3_STORE_NONE) r.mnemonic = MN_SB + f3;
      end
      OPC_BRANCH: begin
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        imm   = $signed({w[31], w[7], w[30:25], w[11:8], 1'b0});
        jumps = 1;
        case (f3)
          F3_BEQ:  r.mnemonic = MN_BEQ;
          F3_BNE:  r.mnemonic = MN_BNE;
          F3_BLT:  r.mnemonic = MN_BLT;
          F3_BGE:  r.mnemonic = MN_BGE;
          F3_BLTU: r.mnemonic = MN_BLTU;
          F3_BGEU: r.mnemonic = MN_BGEU;
          default: r.mnemonic = MN_INVALID;
        endcase
      end
      OPC_JAL: begin
        r.rd       = w[11:7];
        imm        = $signed({w[31], w[19:12], w[20], w[30:21], 1'b0});
        jumps      = 1;
        r.mnemonic = MN_JAL;
      end
      OPC_JALR: begin
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        imm   = $signed(w[31:20]);
        if (f3 == F3_JALR) r.mnemonic = MN_JALR;
      end
      OPC_LUI: begin
        r.rd       = w[11:7];
        imm        = w[31:12];   // raw, not shifted or sign-extended
        r.mnemonic = MN_LUI;
      end
      default: r.mnemonic = MN_INVALID;
    endcase
    if (r.mnemonic == MN_INVALID) begin
      r = '0;
    end else begin
      r.imm = imm[20:0];
      if (jumps) begin
        // int division truncates toward zero, as the target rule wants
        dest = ln + imm / 4;
        if (dest >= 0) begin
          r.has_target  = 1'b1;
          r.target_line = dest[18:0];
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Encoders and random picks for the stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(int imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm[11:0], rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(int imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(int imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(int imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_u(int imm, logic [4:0] rd);
    return {imm[19:0], rd, OPC_LUI};
  endfunction

  // signed value of the given width, biased toward the ends and toward zero
  function automatic int rand_imm(int nbits);
    int span;
    int v;
    span = 1 << nbits;
    case ($urandom_range(7, 0))
      0:       v = span / 2 - 1;
      1:       v = -(span / 2);
      2:       v = $urandom_range(16, 0) - 8;
      default: begin
        v = $urandom_range(span - 1, 0);
        if (v >= span / 2) v = v - span;
      end
    endcase
    return v;
  endfunction

  // small lines make negative branch targets likely
  function automatic logic [15:0] rand_line();
    int r;
    r = $urandom_range(99, 0);
    if (r < 2) return 16'd0;
    if (r < 30) return $urandom_range(16, 1);
    return $urandom_range(65535, 1);
  endfunction

  function automatic logic [31:0] random_encoding(logic [5:0] mn);
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [5:0]  shamt;
    logic [2:0]  f3;
    logic [31:0] w;
    rd    = $urandom;
    rs1   = $urandom;
    rs2   = $urandom;
    shamt = $urandom;
    case (mn)
      MN_ADD:  w = enc_r(F7_BASE, rs2, rs1, F3_ADD_SUB, rd, OPC_OP);
      MN_SUB:  w = enc_r(F7_ALT, rs2, rs1, F3_ADD_SUB, rd, OPC_OP);
      MN_AND:  w = enc_r(F7_BASE, rs2, rs1, F3_AND, rd, OPC_OP);
      MN_OR:   w = enc_r(F7_BASE, rs2, rs1, F3_OR, rd, OPC_OP);
      MN_XOR:  w = enc_r(F7_BASE, rs2, rs1, F3_XOR, rd, OPC_OP);
      MN_SLL:  w = enc_r(F7_BASE, rs2, rs1, F3_SLL, rd, OPC_OP);
      MN_SRL:  w = enc_r(F7_BASE, rs2, rs1, F3_SRL_SRA, rd, OPC_OP);
      MN_SRA:  w = enc_r(F7_ALT, rs2, rs1, F3_SRL_SRA, rd, OPC_OP);
      MN_ADDI: w = enc_i(rand_imm(12), rs1, F3_ADD_SUB, rd, OPC_OPIMM);
      MN_ANDI: w = enc_i(rand_imm(12), rs1, F3_AND, rd, OPC_OPIMM);
      MN_ORI:  w = enc_i(rand_imm(12), rs1, F3_OR, rd, OPC_OPIMM);
      MN_XORI: w = enc_i(rand_imm(12), rs1, F3_XOR, rd, OPC_OPIMM);
      MN_SLLI: w = enc_i({F6_BASE, shamt}, rs1, F3_SLL, rd, OPC_OPIMM);
      MN_SRLI: w = enc_i({F6_BASE, shamt}, rs1, F3_SRL_SRA, rd, OPC_OPIMM);
      MN_SRAI: w = enc_i({F6_ALT, shamt}, rs1, F3_SRL_SRA, rd, OPC_OPIMM);
      MN_LB, MN_LH, MN_LW, MN_LD, MN_LBU, MN_LHU, MN_LWU: begin
        f3 = mn - MN_LB;
        w  = enc_i(rand_imm(12), rs1, f3, rd, OPC_LOAD);
      end
      MN_SB, MN_SH, MN_SW, MN_SD: begin
        f3 = mn - MN_SB;
        w  = enc_s(rand_imm(12), rs2, rs1, f3);
      end
      MN_BEQ:  w = enc_b(rand_imm(13), rs2, rs1, F3_BEQ);
      MN_BNE:  w = enc_b(rand_imm(13), rs2, rs1, F3_BNE);
      MN_BLT:  w = enc_b(rand_imm(13), rs2, rs1, F3_BLT);
      MN_BGE:  w = enc_b(rand_imm(13), rs2, rs1, F3_BGE);
      MN_BLTU: w = enc_b(rand_imm(13), rs2, rs1, F3_BLTU);
      MN_BGEU: w = enc_b(rand_imm(13), rs2, rs1, F3_BGEU);
      MN_JAL:  w = enc_j(rand_imm(21), rd);
      MN_JALR: w = enc_i(rand_imm(12), rs1, F3_JALR, rd, OPC_JALR);
      MN_LUI:  w = enc_u($urandom, rd);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // idle length: mostly none or short, now and then long; none in a burst
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic queue_item(logic [31:0] w, logic [15:0] line, bit drain = 0);
    listing_entry_t e;
    e.word  = w;
    e.line  = line;
    e.drain = drain;
    instr_queue.push_back(e);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: everything changes on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // stretches with no idling at all come and go
      if ($urandom_range(199, 0) == 0) burst = !burst;

      // input side: hold until transfer, then gap, then next word
      if (in_valid && !in_xfer) begin
        // payload stays put
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (instr_queue.size() > 0 &&
                   (!instr_queue[0].drain || pending_decodes.size() == 0)) begin
        next_entry = instr_queue.pop_front();
        instr_word  <= next_entry.word;
        line_number <= next_entry.line;
        in_valid    <= 1'b1;
        gap_left    = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end

      // output side: random stalls of random length
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99, 0) < 25) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled on the rising edge. The output check comes
  // first so a decode can never be matched against a word taken on the same
  // edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual mnemonic %0d",
                   $time, mnemonic);
        end else begin
          want = pending_decodes.pop_front();
          check_field("mnemonic", want.mnemonic, mnemonic);
          check_field("dest_reg", want.rd, dest_reg);
          check_field("src1_reg", want.rs1, src1_reg);
          check_field("src2_reg", want.rs2, src2_reg);
          check_field("immediate", want.imm, immediate[20:0]);
          check_field("has_target", want.has_target, has_target);
          check_field("target_line", want.target_line, target_line);
        end
      end
      if (in_valid && in_ready) begin
        pending_decodes.push_back(decode_instr(instr_word, line_number));
        words_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    instr_word  = '0;
    line_number = '0;

    // directed: field extremes, each major opcode, invalid corners
    queue_item(32'h0000_0000, 16'd1);                                   // unknown opcode
    queue_item(32'hFFFF_FFFF, 16'd65535);                               // all ones
    queue_item(enc_r(F7_BASE, 5'd31, 5'd31, F3_ADD_SUB, 5'd31, OPC_OP), 16'd65535);
    queue_item(enc_r(F7_ALT, 5'd0, 5'd0, F3_ADD_SUB, 5'd0, OPC_OP), 16'd1);
    queue_item(enc_r(F7_ALT, 5'd5, 5'd6, F3_XOR, 5'd7, OPC_OP), 16'd3);   // alt funct7, bad f3
    queue_item(enc_r(7'h01, 5'd1, 5'd2, F3_AND, 5'd3, OPC_OP), 16'd4);    // unknown funct7
    queue_item(enc_i(-1, 5'd31, F3_ADD_SUB, 5'd31, OPC_OPIMM), 16'd5);
    queue_item(enc_i(2047, 5'd0, F3_XOR, 5'd1, OPC_OPIMM), 16'd6);
    queue_item(enc_i({F6_ALT, 6'd63}, 5'd9, F3_SRL_SRA, 5'd10, OPC_OPIMM), 16'd7);
    queue_item(enc_i({6'b000001, 6'd5}, 5'd9, F3_SLL, 5'd10, OPC_OPIMM), 16'd8);
    queue_item(enc_i(100, 5'd1, F3_SLT, 5'd2, OPC_OPIMM), 16'd9);        // no slti here
    queue_item(enc_i(-2048, 5'd31, F3_AND - F3_SRL_SRA + F3_SLL, 5'd31, OPC_LOAD),
               16'd10);                                                // ld, f3 = 3
    queue_item(enc_i(5, 5'd1, F3_LOAD_NONE, 5'd2, OPC_LOAD), 16'd11);
    queue_item(enc_s(-1, 5'd31, 5'd31, F3_STORE_NONE - F3_SLL), 16'd12);  // sd
    queue_item(enc_s(2047, 5'd1, 5'd2, F3_STORE_NONE), 16'd13);
    queue_item(enc_b(-4096, 5'd0, 5'd0, F3_BEQ), 16'd1);                // negative target
    queue_item(enc_b(4094, 5'd31, 5'd31, F3_BGEU), 16'd65535);
    queue_item(enc_b(-4, 5'd1, 5'd2, F3_BNE), 16'd1);                   // lands on zero
    queue_item(enc_b(-6, 5'd3, 5'd4, F3_BLT), 16'd1);                   // rounds toward zero
    queue_item(enc_b(-2, 5'd5, 5'd6, F3_BGE), 16'd1);
    queue_item(enc_b(0, 5'd7, 5'd8, F3_BLTU), 16'd0);                   // line zero
    queue_item(enc_b(8, 5'd7, 5'd8, F3_BRANCH_NONE), 16'd20);
    queue_item(enc_j(1048574, 5'd31), 16'd65535);
    queue_item(enc_j(-1048576, 5'd0), 16'd65535);
    queue_item(enc_i(-1, 5'd31, F3_JALR, 5'd31, OPC_JALR), 16'd30);
    queue_item(enc_i(4, 5'd1, F3_JALR_NONE, 5'd2, OPC_JALR), 16'd31);
    queue_item(enc_u(32'hFFFFF, 5'd31), 16'd32);

    // random: mostly valid encodings, the rest garbage or one bit off valid.
    // Now and then the sender waits for the block to empty.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mn_pick = $urandom_range(35, 1);
      if ($urandom_range(99, 0) < 85) begin
        noise_word = random_encoding(mn_pick);
      end else if ($urandom_range(1, 0) == 0) begin
        noise_word = $urandom;
      end else begin
        noise_word = random_encoding(mn_pick) ^ (32'd1 << $urandom_range(31, 0));
      end
      queue_item(noise_word, rand_line(), i % 500 == 0);
    end
    words_total = instr_queue.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_taken < words_total) @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // anything extra would show up in this window

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
